>>> rtl/command_line_splitter_core_defines.svh
// Assertion macros for the command line splitter RTL, included by cls_queue.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef COMMAND_LINE_SPLITTER_CORE_DEFINES_SVH
`define COMMAND_LINE_SPLITTER_CORE_DEFINES_SVH

`ifndef SYNTH
`define CLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define CLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CLS_ASSERT(lbl, prop, msg)
`define CLS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/cls_pkg.sv
// Shared types and constants of the command line splitter.
// Used by cls_front, cls_queue and command_line_splitter_core.
package cls_pkg;

    localparam int MAX_LINE_DEF = 1024;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] line_byte;
        logic       byte_valid;
        logic       line_end;
    } t_result;

    typedef struct packed {
        logic    first;
        logic    second;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

>>> rtl/command_line_splitter_core.sv
// Top level of the command line splitter: front end and result queue.
// Depends on cls_pkg, cls_front and cls_queue.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_ready  | i_data_byte, i_last_byte
//  result  | out       | o_valid / i_ready  | o_line_byte, o_byte_valid, o_line_end
//
// One byte transfer is taken per cycle while the queue has room; it yields zero, one or two results.
// Results are registered in the queue and leave it one per cycle while i_ready is high.
// The four-entry queue sets the rate: input stalls while fewer than two entries are free.
// Reset is synchronous and active low; it clears the scan state and empties the queue.
module command_line_splitter_core #(
    parameter int MAX_LINE = cls_pkg::MAX_LINE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_line_byte,
    output logic       o_byte_valid,
    output logic       o_line_end
);

    cls_pkg::t_push push;
    logic           space;

    cls_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_space     (space),
        .o_ready     (o_ready),
        .o_push      (push)
    );

    cls_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_space      (space),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_line_byte  (o_line_byte),
        .o_byte_valid (o_byte_valid),
        .o_line_end   (o_line_end)
    );

endmodule

>>> rtl/cls_front.sv
// Front end of the command line splitter: takes byte transfers, holds one byte
// of lookahead, tracks quote and comment state and classifies line breaks.
// Depends on cls_pkg.
module cls_front #(
    parameter int MAX_LINE = cls_pkg::MAX_LINE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_space,
    output logic              o_ready,
    output cls_pkg::t_push    o_push
);

    localparam int LEN_W = $clog2(MAX_LINE);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE - 1);

    typedef enum logic [1:0] {
        BRK_NONE,
        BRK_SEP,
        BRK_STAR
    } t_brk;

    typedef struct packed {
        logic             quote_odd;
        logic             line_cmt;
        logic             block_cmt;
        logic             skip_sep;
        logic             drop_next;
        logic [LEN_W-1:0] len;
    } t_st;

    typedef struct packed {
        t_st              st;
        logic             emit;
        cls_pkg::t_result res;
    } t_scan;

    function automatic t_scan scan(t_st s, logic [7:0] c, logic [7:0] nx, logic has_nx);
        t_scan o;
        logic  q;
        logic  lc;
        logic  bc;
        logic  nl;
        t_brk  brk;
        o      = '0;
        o.st   = s;
        q      = s.quote_odd ^ (c == cls_pkg::CH_QUOTE);
        lc     = s.line_cmt;
        bc     = s.block_cmt;
        nl     = (c == cls_pkg::CH_LF) || (c == cls_pkg::CH_CR);
        brk    = BRK_NONE;
        if (s.drop_next) begin
            o.st.drop_next = 1'b0;
        end else if (!(s.skip_sep && (nl || c == cls_pkg::CH_SEMI))) begin
            o.st.skip_sep = 1'b0;
            if (!q) begin
                if (has_nx) begin
                    if (!bc && c == cls_pkg::CH_SLASH && nx == cls_pkg::CH_SLASH) begin
                        lc = 1'b1;
                    end else if (!lc && c == cls_pkg::CH_SLASH && nx == cls_pkg::CH_STAR) begin
                        bc = 1'b1;
                    end else if (bc && c == cls_pkg::CH_STAR && nx == cls_pkg::CH_SLASH) begin
                        bc  = 1'b0;
                        brk = BRK_STAR;
                    end
                end
                if (brk == BRK_NONE && !lc && !bc && c == cls_pkg::CH_SEMI) begin
                    brk = BRK_SEP;
                end
            end
            if (brk == BRK_NONE && !bc && nl) begin
                lc  = 1'b0;
                brk = BRK_SEP;
            end
            o.emit = 1'b1;
            if (brk != BRK_SEP && s.len >= LEN_MAX) begin
                // The line is full: cut it and discard this byte.
                o.res.line_end = 1'b1;
                o.st.len       = '0;
                o.st.quote_odd = 1'b0;
                o.st.skip_sep  = 1'b1;
            end else begin
                o.st.quote_odd = q;
                o.st.line_cmt  = lc;
                o.st.block_cmt = bc;
                case (brk)
                    BRK_SEP: begin
                        o.res.line_end = 1'b1;
                        o.st.len       = '0;
                        o.st.quote_odd = 1'b0;
                        o.st.skip_sep  = 1'b1;
                    end
                    BRK_STAR: begin
                        o.res.line_byte  = c;
                        o.res.byte_valid = 1'b1;
                        o.res.line_end   = 1'b1;
                        o.st.len         = '0;
                        o.st.quote_odd   = 1'b0;
                        o.st.skip_sep    = 1'b1;
                        o.st.drop_next   = 1'b1;
                    end
                    default: begin
                        o.res.line_byte  = c;
                        o.res.byte_valid = 1'b1;
                        o.st.len         = s.len + 1'b1;
                    end
                endcase
            end
        end
        return o;
    endfunction

    t_st        r_st;
    t_st        n_st;
    logic [7:0] r_held;
    logic       r_held_vld;
    logic       n_held_vld;
    logic       accept;
    t_scan      scan_a;
    t_scan      scan_b;
    t_st        st_mid;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    always_comb begin
        scan_a = '0;
        scan_a.st = r_st;
        if (r_held_vld) begin
            scan_a = scan(r_st, r_held, i_data_byte, 1'b1);
        end
        st_mid = scan_a.st;
        scan_b = '0;
        scan_b.st = st_mid;
        if (i_last_byte) begin
            scan_b = scan(st_mid, i_data_byte, 8'h00, 1'b0);
        end

        o_push = '0;
        if (accept) begin
            if (scan_a.emit) begin
                o_push.first  = 1'b1;
                o_push.r0     = scan_a.res;
                o_push.second = scan_b.emit;
                o_push.r1     = scan_b.res;
            end else begin
                o_push.first  = scan_b.emit;
                o_push.r0     = scan_b.res;
            end
            // The final byte closes any line that is still open.
            if (i_last_byte && scan_b.st.len != '0) begin
                if (o_push.second) begin
                    o_push.r1.line_end = 1'b1;
                end else if (o_push.first && !o_push.r0.line_end) begin
                    o_push.r0.line_end = 1'b1;
                end else if (o_push.first) begin
                    o_push.second = 1'b1;
                    o_push.r1     = '{line_byte: 8'h00, byte_valid: 1'b0, line_end: 1'b1};
                end else begin
                    o_push.first = 1'b1;
                    o_push.r0    = '{line_byte: 8'h00, byte_valid: 1'b0, line_end: 1'b1};
                end
            end
        end

        n_st       = r_st;
        n_held_vld = r_held_vld;
        if (accept) begin
            if (i_last_byte) begin
                n_st       = '0;
                n_held_vld = 1'b0;
            end else begin
                n_st       = scan_a.st;
                n_held_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= '0;
            r_held_vld <= 1'b0;
        end else begin
            r_st       <= n_st;
            r_held_vld <= n_held_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= i_data_byte;
        end
    end

endmodule

>>> rtl/cls_queue.sv
// Back end of the command line splitter: a short result queue that takes up
// to two results per cycle and delivers one per output transfer.
// Depends on cls_pkg and command_line_splitter_core_defines.svh.
`include "command_line_splitter_core_defines.svh"

module cls_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cls_pkg::t_push i_push,
    output logic           o_space,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_line_byte,
    output logic           o_byte_valid,
    output logic           o_line_end
);

    cls_pkg::t_result            r_mem [cls_pkg::QDEPTH];
    logic [cls_pkg::QPTR_W-1:0] r_wr;
    logic [cls_pkg::QPTR_W-1:0] r_rd;
    logic [cls_pkg::QCNT_W-1:0] r_cnt;
    logic [cls_pkg::QPTR_W-1:0] n_wr;
    logic [cls_pkg::QPTR_W-1:0] n_rd;
    logic [cls_pkg::QCNT_W-1:0] n_cnt;
    logic [cls_pkg::QPTR_W-1:0] wr_next;
    logic [cls_pkg::QCNT_W-1:0] push_cnt;
    logic                        pop;
    cls_pkg::t_result            head;

    assign o_space  = r_cnt <= cls_pkg::QCNT_W'(cls_pkg::QDEPTH - 2);
    assign o_valid  = r_cnt != '0;
    assign pop      = o_valid && i_ready;
    assign head     = r_mem[r_rd];
    assign wr_next  = r_wr + 1'b1;
    assign push_cnt = cls_pkg::QCNT_W'(i_push.first) + cls_pkg::QCNT_W'(i_push.second);

    assign o_line_byte  = head.line_byte;
    assign o_byte_valid = head.byte_valid;
    assign o_line_end   = head.line_end;

    always_comb begin
        n_wr  = r_wr + push_cnt[cls_pkg::QPTR_W-1:0];
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + push_cnt - cls_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.second) begin
            r_mem[wr_next] <= i_push.r1;
        end
    end

    `CLS_ASSERT(a_cnt_bound, r_cnt <= cls_pkg::QCNT_W'(cls_pkg::QDEPTH), "queue count overflow")
    `CLS_ASSERT(a_push_order, !i_push.second || i_push.first, "second result without first")
    `CLS_ASSERT(a_push_room, !i_push.first || o_space, "push into a full queue")
    `CLS_ASSERT_NEXT(a_drain, r_cnt == 1 && pop && !i_push.first, !o_valid, "queue did not drain")

endmodule

>>> bench/command_line_splitter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for command_line_splitter_core: random and directed command text.
// Depends on cls_pkg and the command_line_splitter_core RTL.
module command_line_splitter_core_tb;

    localparam int LINE_CAP = cls_pkg::MAX_LINE_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int TOTAL_ITEMS = 1200;

    typedef enum int {END_NONE, END_SEP, END_STAR} t_line_break;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_text_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_line_byte;
    logic       o_byte_valid;
    logic       o_line_end;

    t_text_byte       bytes_to_send[$];
    t_text_byte       next_item;
    logic [7:0]       text_buf[$];
    cls_pkg::t_result results_due[$];
    cls_pkg::t_result step_res[2];
    cls_pkg::t_result want;
    int               step_cnt;

    logic [7:0] look_byte;
    bit         look_ok;
    bit         quote_odd;
    bit         in_line_cmt;
    bit         in_block_cmt;
    bit         skip_sep;
    bit         drop_slash;
    int         line_len;

    int  total_items = 0;
    int  sent_count = 0;
    int  rx_count = 0;
    int  err_count = 0;
    int  idle_cycles = 0;
    bit  in_fired = 1'b0;
    bit  out_fired = 1'b0;
    bit  in_calm = 1'b0;
    bit  out_calm = 1'b0;
    bit  rx_hold = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;

    command_line_splitter_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_line_byte  (o_line_byte),
        .o_byte_valid (o_byte_valid),
        .o_line_end   (o_line_end)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_scan();
        look_byte = 8'h00;
        look_ok = 1'b0;
        quote_odd = 1'b0;
        in_line_cmt = 1'b0;
        in_block_cmt = 1'b0;
        skip_sep = 1'b0;
        drop_slash = 1'b0;
        line_len = 0;
    endfunction

    function automatic void note_result(logic [7:0] b, logic v, logic e);
        if (step_cnt < 2) begin
            step_res[step_cnt].line_byte = b;
            step_res[step_cnt].byte_valid = v;
            step_res[step_cnt].line_end = e;
            step_cnt++;
        end
    endfunction

    function automatic void close_line();
        line_len = 0;
        quote_odd = 1'b0;
        skip_sep = 1'b1;
    endfunction

    function automatic void scan_char(logic [7:0] c, logic [7:0] nx, bit has_nx);
        bit q;
        bit lc;
        bit bc;
        t_line_break brk;
        brk = END_NONE;
        if (drop_slash) begin
            drop_slash = 1'b0;
            return;
        end
        if (skip_sep) begin
            if (c == cls_pkg::CH_LF || c == cls_pkg::CH_CR || c == cls_pkg::CH_SEMI) begin
                return;
            end
            skip_sep = 1'b0;
        end
        q = quote_odd;
        lc = in_line_cmt;
        bc = in_block_cmt;
        if (c == cls_pkg::CH_QUOTE) begin
            q = !q;
        end
        if (!q) begin
            if (has_nx) begin
                if (!bc && c == cls_pkg::CH_SLASH && nx == cls_pkg::CH_SLASH) begin
                    lc = 1'b1;
                end else if (!lc && c == cls_pkg::CH_SLASH && nx == cls_pkg::CH_STAR) begin
                    bc = 1'b1;
                end else if (bc && c == cls_pkg::CH_STAR && nx == cls_pkg::CH_SLASH) begin
                    bc = 1'b0;
                    brk = END_STAR;
                end
            end
            if (brk == END_NONE && !lc && !bc && c == cls_pkg::CH_SEMI) begin
                brk = END_SEP;
            end
        end
        if (brk == END_NONE && !bc && (c == cls_pkg::CH_LF || c == cls_pkg::CH_CR)) begin
            lc = 1'b0;
            brk = END_SEP;
        end
        if (brk != END_SEP && line_len >= LINE_CAP - 1) begin
            note_result(8'h00, 1'b0, 1'b1);
            close_line();
            return;
        end
        quote_odd = q;
        in_line_cmt = lc;
        in_block_cmt = bc;
        if (brk == END_SEP) begin
            note_result(8'h00, 1'b0, 1'b1);
            close_line();
        end else if (brk == END_STAR) begin
            note_result(c, 1'b1, 1'b1);
            close_line();
            drop_slash = 1'b1;
        end else begin
            note_result(c, 1'b1, 1'b0);
            line_len++;
        end
    endfunction

    function automatic void split_byte(logic [7:0] b, logic last);
        step_cnt = 0;
        if (look_ok) begin
            scan_char(look_byte, b, 1'b1);
        end
        look_byte = b;
        look_ok = 1'b1;
        if (last) begin
            scan_char(look_byte, 8'h00, 1'b0);
            look_ok = 1'b0;
            if (line_len > 0) begin
                if (step_cnt > 0 && !step_res[step_cnt - 1].line_end) begin
                    step_res[step_cnt - 1].line_end = 1'b1;
                end else begin
                    note_result(8'h00, 1'b0, 1'b1);
                end
            end
            clear_scan();
        end
        for (int i = 0; i < step_cnt; i++) begin
            results_due.push_back(step_res[i]);
        end
    endfunction

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] fill_char();
        case ($urandom_range(0, 5))
            0: return cls_pkg::CH_QUOTE;
            1: return cls_pkg::CH_SLASH;
            2: return 8'h20;
            default: return 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    task automatic flush_buffer();
        t_text_byte item;
        for (int i = 0; i < text_buf.size(); i++) begin
            item.data = text_buf[i];
            item.last = (i == text_buf.size() - 1);
            bytes_to_send.push_back(item);
            total_items++;
        end
        text_buf.delete();
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            text_buf.push_back(s[i]);
        end
    endtask

    task automatic add_token(int kind);
        int n;
        case (kind)
            0: begin
                n = $urandom_range(1, 6);
                repeat (n) text_buf.push_back(8'(8'h61 + $urandom_range(0, 25)));
            end
            1: text_buf.push_back(8'h20);
            2: text_buf.push_back(cls_pkg::CH_QUOTE);
            3: text_buf.push_back(cls_pkg::CH_SEMI);
            4: text_buf.push_back(cls_pkg::CH_LF);
            5: text_buf.push_back(cls_pkg::CH_CR);
            6: add_text("//");
            7: add_text("/*");
            8: add_text("*/");
            9: text_buf.push_back(cls_pkg::CH_SLASH);
            10: text_buf.push_back(cls_pkg::CH_STAR);
            default: text_buf.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int exp_val);
        err_count++;
        $display("mismatch at result %0d: %s is %0h, expected %0h",
                 rx_count, what, got, exp_val);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fired) begin
            if (in_fired) begin
                if ($urandom_range(0, 79) == 0) begin
                    in_calm = !in_calm;
                end
                in_gap = draw_gap(in_calm);
            end
            if (in_gap > 0) begin
                in_gap--;
                i_valid <= 1'b0;
            end else if (bytes_to_send.size() > 0) begin
                next_item = bytes_to_send.pop_front();
                i_valid <= 1'b1;
                i_data_byte <= next_item.data;
                i_last_byte <= next_item.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_fired) begin
            if ($urandom_range(0, 79) == 0) begin
                out_calm = !out_calm;
            end
            out_gap = draw_gap(out_calm);
        end
        if (!i_rst_n || rx_hold) begin
            i_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        in_fired = i_rst_n && i_valid && o_ready;
        out_fired = i_rst_n && o_valid && i_ready;
        if (in_fired) begin
            split_byte(i_data_byte, i_last_byte);
            sent_count++;
        end
        if (out_fired) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected transfer, line byte", int'(o_line_byte), 0);
            end else begin
                want = results_due.pop_front();
                if (o_line_byte !== want.line_byte) begin
                    report_mismatch("line byte", int'(o_line_byte), int'(want.line_byte));
                end
                if (o_byte_valid !== want.byte_valid) begin
                    report_mismatch("byte valid", int'(o_byte_valid), int'(want.byte_valid));
                end
                if (o_line_end !== want.line_end) begin
                    report_mismatch("line end", int'(o_line_end), int'(want.line_end));
                end
            end
            rx_count++;
        end
        if (i_rst_n && !in_fired && !out_fired) begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL command_line_splitter_core");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    initial begin
        while (sent_count < 400) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (240) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        int n;
        clear_scan();

        add_text(";");
        flush_buffer();
        add_text("\"a;\"/*;\n*/b");
        flush_buffer();
        add_text("//c;\r\n;x");
        flush_buffer();
        text_buf.push_back(8'h00);
        text_buf.push_back(8'hFF);
        flush_buffer();

        repeat (LINE_CAP + 2) text_buf.push_back(fill_char());
        add_text(";z");
        flush_buffer();

        while (total_items < TOTAL_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 20);
                repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                n = $urandom_range(1, 24);
                repeat (n) add_token($urandom_range(0, 11));
            end
            flush_buffer();
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (sent_count < total_items) @(posedge i_clk);
        while (results_due.size() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS command_line_splitter_core");
        end else begin
            $display("FAIL command_line_splitter_core");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cls_pkg.sv
rtl/cls_front.sv
rtl/cls_queue.sv
rtl/command_line_splitter_core.sv
bench/command_line_splitter_core_tb.sv
